### sv/frc_pkg.sv
package frc_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CAP_BITS   = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(DEPTH);

   // transaction kinds carried on req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic insert;   // write the request into the ring
      logic capture;  // latch the lookup key
      logic match;    // register the per-entry compare vector
      logic pick;     // select the oldest matching entry
      logic load;     // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free; // result register empty or being drained
   } status_type;

endpackage

### sv/fifo_replacement_cache.sv
// Key/value store with first-in-first-out replacement, holding up to 16
// entries in a register ring. Each request transaction carries an opcode on
// req_tuser: an insert appends key and value behind the newest entry, first
// evicting the oldest one when the entry count has reached the capacity
// register (capacities above 16 act as 16; capacity zero drops inserts while
// the ring is empty). Duplicate keys are kept as separate entries. A lookup
// returns one response transaction with found on rsp_tuser and the value of
// the oldest matching entry on rsp_tdata (zero on a miss); an insert returns
// nothing and leaves the request port open. A lookup occupies it through four
// steps: accept and latch the key, register the parallel compare of all 16
// entries, select the oldest match in age order, then load the response
// register. The last step waits while an earlier response is still held
// unread, so a stalled consumer stretches lookups but not inserts. Write
// capacity through csr_wr_en / csr_wr_data only while no lookup is outstanding.
module fifo_replacement_cache (
   input  logic                          clock,
   input  logic                          reset,
   // capacity register
   input  logic                          csr_wr_en,
   input  logic [frc_pkg::CAP_BITS-1:0]  csr_wr_data,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,  // key [31:0], value [63:32]
   input  logic [0:0]                    req_tuser,  // opcode [0]
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // read_value [31:0]
   output logic [0:0]                    rsp_tuser   // found [0]
);

   frc_pkg::cmd_type    cmd;
   frc_pkg::status_type status;

   // sequence each transaction
   frc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the entry ring, the compare/select path and the response register
   frc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_key     (req_tdata[31:0]),
      .req_value   (req_tdata[63:32]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_found   (rsp_tuser[0]),
      .rsp_value   (rsp_tdata)
   );

endmodule

### sv/frc_ctrl.sv
module frc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_op,
   output logic                  req_tready,
   input  frc_pkg::status_type   status,
   output frc_pkg::cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_PICK  = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == frc_pkg::OP_LOOKUP) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MATCH;
               end else begin
                  cmd.insert = 1'b1;
               end
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold until the result register can take the lookup result
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/frc_datapath.sv
module frc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [frc_pkg::CAP_BITS-1:0]       csr_wr_data,
   input  logic [frc_pkg::KEY_BITS-1:0]       req_key,
   input  logic [frc_pkg::VALUE_BITS-1:0]     req_value,
   input  frc_pkg::cmd_type                   cmd,
   output frc_pkg::status_type                status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_found,
   output logic [frc_pkg::VALUE_BITS-1:0]     rsp_value
);

   localparam int IB = frc_pkg::IDX_BITS;
   localparam int CB = frc_pkg::CNT_BITS;

   logic [frc_pkg::KEY_BITS-1:0]   key_ff   [frc_pkg::DEPTH];
   logic [frc_pkg::VALUE_BITS-1:0] value_ff [frc_pkg::DEPTH];

   logic [IB-1:0]                  oldest_ff, oldest_in;
   logic [CB-1:0]                  count_ff, count_in;
   logic [frc_pkg::CAP_BITS-1:0]   capacity_ff;
   logic [frc_pkg::KEY_BITS-1:0]   lookup_key_ff;
   logic [frc_pkg::DEPTH-1:0]      match_ff, match_in;
   logic                           hit_ff, hit_in;
   logic [IB-1:0]                  hit_slot_ff, hit_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff;
   logic [frc_pkg::VALUE_BITS-1:0] rsp_value_ff;

   logic [frc_pkg::CAP_BITS-1:0]   eff_cap;
   logic                           full;
   logic                           write_en;
   logic [IB-1:0]                  write_slot;

   // insert: evict the oldest when full, then append behind the newest
   always_comb begin
      eff_cap    = (capacity_ff > frc_pkg::CAP_RESET) ? frc_pkg::CAP_RESET : capacity_ff;
      full       = count_ff >= CB'(eff_cap);
      write_en   = cmd.insert && !(full && count_ff == '0);
      write_slot = oldest_ff + count_ff[IB-1:0];
      oldest_in  = (write_en && full) ? oldest_ff + IB'(1) : oldest_ff;
      count_in   = (write_en && !full) ? count_ff + CB'(1) : count_ff;
   end

   // compare every live entry against the lookup key
   always_comb begin
      logic [IB-1:0] age;
      for (int s = 0; s < frc_pkg::DEPTH; s++) begin
         age         = IB'(s) - oldest_ff;
         match_in[s] = (CB'(age) < count_ff) && (key_ff[s] == lookup_key_ff);
      end
   end

   // rotate to age order and take the oldest match
   always_comb begin
      logic [IB-1:0] pos;
      logic [IB-1:0] slot;
      pos    = '0;
      hit_in = 1'b0;
      for (int i = frc_pkg::DEPTH - 1; i >= 0; i--) begin
         slot = oldest_ff + IB'(i);
         if (match_ff[slot]) begin
            hit_in = 1'b1;
            pos    = IB'(i);
         end
      end
      hit_slot_in = oldest_ff + pos;
   end

   always_comb begin
      status.out_free = !rsp_valid_ff || rsp_tready;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         capacity_ff  <= frc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < frc_pkg::DEPTH; s++) begin
         if (write_en && write_slot == IB'(s)) begin
            key_ff[s]   <= req_key;
            value_ff[s] <= req_value;
         end
      end
      if (cmd.capture) begin
         lookup_key_ff <= req_key;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      if (cmd.pick) begin
         hit_ff      <= hit_in;
         hit_slot_ff <= hit_slot_in;
      end
      if (cmd.load) begin
         rsp_found_ff <= hit_ff;
         rsp_value_ff <= hit_ff ? value_ff[hit_slot_ff] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

### sv/frc_checker.sv
module frc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a held response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a lookup blocks the request port in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == frc_pkg::OP_LOOKUP |=> !req_tready)
      else $error("request port open during lookup");

   // an insert leaves the request port open in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == frc_pkg::OP_INSERT |=> req_tready)
      else $error("insert held the request port");

   // a miss reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss with nonzero data");

endmodule

bind fifo_replacement_cache frc_checker u_frc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
